/* design/psg_pkg.sv */
// ----------------------------------------------------------------------------
// psg_pkg: shared types and constants for the permutation step generator
// Direction codes, reset defaults, output item layout and store control.
// ----------------------------------------------------------------------------
package psg_pkg;

  // Direction bit codes
  localparam logic LEFT  = 1'b0;
  localparam logic RIGHT = 1'b1;

  // Build size default and register reset
  localparam int unsigned MAX_ELEMS_DEF = 8;
  localparam int unsigned ELEM_COUNT_W  = 4;
  localparam logic [ELEM_COUNT_W-1:0] ELEM_COUNT_RST = 4'd8;

  // Output field types (fixed widths of the result item)
  typedef logic [3:0] elem_value_t;
  typedef logic [2:0] elem_pos_t;

  typedef struct packed {
    elem_value_t value;
    elem_pos_t   position;
    logic        last;
    logic        finished;
  } out_item_t;

  // Store control strobes from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } st_ctl_t;

endpackage

/* design/psg_store.sv */
// ----------------------------------------------------------------------------
// psg_store: permutation and direction store
// One write port, one registered read port; per-entry valid bits make an
// unwritten entry read as the identity value with direction LEFT.
// ----------------------------------------------------------------------------
module psg_store #(
  parameter int unsigned MAX_ELEMS = psg_pkg::MAX_ELEMS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  psg_pkg::st_ctl_t                    ctl_i,
  input  logic [$clog2(MAX_ELEMS)-1:0]        rd_addr_i,
  input  logic [$clog2(MAX_ELEMS)-1:0]        wr_addr_i,
  input  logic [$clog2(MAX_ELEMS+1):0]        wr_data_i,
  output logic [$clog2(MAX_ELEMS+1):0]        rd_data_o,
  output logic [$clog2(MAX_ELEMS)-1:0]        rd_idx_o
);

  localparam int unsigned IW = $clog2(MAX_ELEMS);
  localparam int unsigned VW = $clog2(MAX_ELEMS + 1);
  localparam int unsigned EW = VW + 1;

  logic [EW-1:0]        mem_q [MAX_ELEMS];
  logic [MAX_ELEMS-1:0] vld_q;
  logic [EW-1:0]        rd_mem_q;
  logic                 rd_vld_q;
  logic [IW-1:0]        rd_idx_q;

  // Array and read data: no reset needed
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_mem_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      if (ctl_i.clr) begin
        vld_q <= '0;
      end else if (ctl_i.wr_en) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr_i];
        rd_idx_q <= rd_addr_i;
      end
    end
  end

  // Unwritten entry: position i holds i+1, pointing left
  assign rd_data_o = rd_vld_q ? rd_mem_q
                              : {psg_pkg::LEFT, VW'(rd_idx_q) + VW'(1)};
  assign rd_idx_o  = rd_idx_q;

endmodule

/* design/psg_ctrl.sv */
// ----------------------------------------------------------------------------
// psg_ctrl: step sequencer with shared comparator
// Scans for the largest mobile element, swaps it, then streams the
// permutation while flipping directions of larger elements.
// ----------------------------------------------------------------------------
module psg_ctrl #(
  parameter int unsigned MAX_ELEMS = psg_pkg::MAX_ELEMS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_fire_i,
  input  logic                                restart_i,
  input  logic [$clog2(MAX_ELEMS+1)-1:0]      n_i,
  input  logic                                slot_free_i,
  input  logic [$clog2(MAX_ELEMS+1):0]        rd_data_i,
  input  logic [$clog2(MAX_ELEMS)-1:0]        rd_idx_i,
  output logic                                busy_o,
  output psg_pkg::st_ctl_t                    st_ctl_o,
  output logic [$clog2(MAX_ELEMS)-1:0]        rd_addr_o,
  output logic [$clog2(MAX_ELEMS)-1:0]        wr_addr_o,
  output logic [$clog2(MAX_ELEMS+1):0]        wr_data_o,
  output logic                                push_o,
  output psg_pkg::out_item_t                  item_o
);

  localparam int unsigned IW = $clog2(MAX_ELEMS);
  localparam int unsigned CW = $clog2(MAX_ELEMS + 1);
  localparam int unsigned VW = CW;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SWAP_A, S_SWAP_B, S_EMIT, S_FIN
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          rv_q, rv_d;
  logic          have_prev_q, have_prev_d;
  logic          pend_q, pend_d;
  logic          flip_q, flip_d;
  logic [VW-1:0] prev_val_q, prev_val_d;
  logic          prev_dir_q, prev_dir_d;
  logic [IW-1:0] prev_idx_q, prev_idx_d;
  logic [VW-1:0] best_val_q, best_val_d;
  logic          best_dir_q, best_dir_d;
  logic [IW-1:0] best_pos_q, best_pos_d;
  logic [VW-1:0] oth_val_q, oth_val_d;
  logic          oth_dir_q, oth_dir_d;
  logic [IW-1:0] oth_pos_q, oth_pos_d;

  logic [VW-1:0] new_val;
  logic          new_dir;
  logic [VW-1:0] cmp_b;
  logic          gt;
  logic          cand_mob;
  logic [VW-1:0] cand_val;
  logic          cand_dir;
  logic [IW-1:0] cand_pos;
  logic [VW-1:0] cand_oth_val;
  logic          cand_oth_dir;
  logic [IW-1:0] cand_oth_pos;
  logic          more;

  assign new_val = rd_data_i[VW-1:0];
  assign new_dir = rd_data_i[VW];

  // Shared comparator: neighbor pair during scan, moved value during emit
  assign cmp_b = (state_q == S_EMIT) ? best_val_q : prev_val_q;
  assign gt    = new_val > cmp_b;

  // Pair (prev, new): larger one is mobile if it points at the other
  assign cand_mob     = gt ? (new_dir == psg_pkg::LEFT) : (prev_dir_q == psg_pkg::RIGHT);
  assign cand_val     = gt ? new_val    : prev_val_q;
  assign cand_dir     = gt ? new_dir    : prev_dir_q;
  assign cand_pos     = gt ? rd_idx_i   : prev_idx_q;
  assign cand_oth_val = gt ? prev_val_q : new_val;
  assign cand_oth_dir = gt ? prev_dir_q : new_dir;
  assign cand_oth_pos = gt ? prev_idx_q : rd_idx_i;

  assign more = cnt_q < n_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rv_d        = rv_q;
    have_prev_d = have_prev_q;
    pend_d      = pend_q;
    flip_d      = flip_q;
    prev_val_d  = prev_val_q;
    prev_dir_d  = prev_dir_q;
    prev_idx_d  = prev_idx_q;
    best_val_d  = best_val_q;
    best_dir_d  = best_dir_q;
    best_pos_d  = best_pos_q;
    oth_val_d   = oth_val_q;
    oth_dir_d   = oth_dir_q;
    oth_pos_d   = oth_pos_q;
    st_ctl_o    = '0;
    rd_addr_o   = cnt_q[IW-1:0];
    wr_addr_o   = '0;
    wr_data_o   = '0;
    push_o      = 1'b0;
    item_o      = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          cnt_d = '0;
          if (restart_i) begin
            st_ctl_o.clr = 1'b1;
            flip_d       = 1'b0;
            pend_d       = 1'b0;
            state_d      = S_EMIT;
          end else begin
            flip_d      = 1'b1;
            rv_d        = 1'b0;
            have_prev_d = 1'b0;
            best_val_d  = '0;
            state_d     = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        st_ctl_o.rd_en = more;
        rv_d           = more;
        if (more) begin
          cnt_d = cnt_q + CW'(1);
        end
        if (rv_q) begin
          if (have_prev_q && cand_mob && (cand_val > best_val_q)) begin
            best_val_d = cand_val;
            best_dir_d = cand_dir;
            best_pos_d = cand_pos;
            oth_val_d  = cand_oth_val;
            oth_dir_d  = cand_oth_dir;
            oth_pos_d  = cand_oth_pos;
          end
          prev_val_d  = new_val;
          prev_dir_d  = new_dir;
          prev_idx_d  = rd_idx_i;
          have_prev_d = 1'b1;
        end
        if (!more) begin
          state_d = S_SWAP_A;
        end
      end

      S_SWAP_A: begin
        if (best_val_q == '0) begin
          state_d = S_FIN;
        end else begin
          st_ctl_o.wr_en = 1'b1;
          wr_addr_o      = best_pos_q;
          wr_data_o      = {oth_dir_q, oth_val_q};
          state_d        = S_SWAP_B;
        end
      end

      S_SWAP_B: begin
        st_ctl_o.wr_en = 1'b1;
        wr_addr_o      = oth_pos_q;
        wr_data_o      = {best_dir_q, best_val_q};
        cnt_d          = '0;
        pend_d         = 1'b0;
        state_d        = S_EMIT;
      end

      S_EMIT: begin
        if (!pend_q) begin
          st_ctl_o.rd_en = 1'b1;
          cnt_d          = cnt_q + CW'(1);
          pend_d         = 1'b1;
        end else if (slot_free_i) begin
          push_o          = 1'b1;
          item_o.value    = psg_pkg::elem_value_t'(new_val);
          item_o.position = psg_pkg::elem_pos_t'(rd_idx_i);
          item_o.last     = !more;
          // Larger than the moved element: reverse direction
          st_ctl_o.wr_en  = flip_q;
          wr_addr_o       = rd_idx_i;
          wr_data_o       = {new_dir ^ gt, new_val};
          if (more) begin
            st_ctl_o.rd_en = 1'b1;
            cnt_d          = cnt_q + CW'(1);
          end else begin
            pend_d  = 1'b0;
            state_d = S_IDLE;
          end
        end
      end

      S_FIN: begin
        if (slot_free_i) begin
          push_o          = 1'b1;
          item_o.last     = 1'b1;
          item_o.finished = 1'b1;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rv_q        <= 1'b0;
      have_prev_q <= 1'b0;
      pend_q      <= 1'b0;
      flip_q      <= 1'b0;
      prev_val_q  <= '0;
      prev_dir_q  <= psg_pkg::LEFT;
      prev_idx_q  <= '0;
      best_val_q  <= '0;
      best_dir_q  <= psg_pkg::LEFT;
      best_pos_q  <= '0;
      oth_val_q   <= '0;
      oth_dir_q   <= psg_pkg::LEFT;
      oth_pos_q   <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rv_q        <= rv_d;
      have_prev_q <= have_prev_d;
      pend_q      <= pend_d;
      flip_q      <= flip_d;
      prev_val_q  <= prev_val_d;
      prev_dir_q  <= prev_dir_d;
      prev_idx_q  <= prev_idx_d;
      best_val_q  <= best_val_d;
      best_dir_q  <= best_dir_d;
      best_pos_q  <= best_pos_d;
      oth_val_q   <= oth_val_d;
      oth_dir_q   <= oth_dir_d;
      oth_pos_q   <= oth_pos_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

/* design/permutation_step_generator.sv */
// ----------------------------------------------------------------------------
// permutation_step_generator: Johnson-Trotter permutation stepper
// Holds the current permutation and direction bits; each item restarts at the
// identity or takes one plain-changes step, and the resulting permutation is
// streamed out one element per result item, or one finished item if none moves.
//
//   channel  | dir | handshake                    | payload
//   ---------+-----+------------------------------+---------------------------
//   in       | in  | in_valid_i / in_stall_o      | restart_i
//   out      | out | out_valid_o / out_stall_i    | elem_value_o, elem_position_o,
//            |     |                              | last_elem_o, finished_o
//   cfg      | in  | cfg_valid_i / cfg_ready_o    | cfg_elem_count_i
//
// The single read port of the permutation store shapes each item: the
//   scan reads one entry a cycle, the swap takes two writes, and the
//   output stream reads one entry a cycle while not stalled, writing
//   back flipped directions on a step.
// Reset leaves the identity with all directions left and N = 8; no
// clearing pass, the store's valid bits clear at once.
// Output stalls hold the stream in place; a new item is taken once the
// sequencer is idle, even while the last result still waits.
// ----------------------------------------------------------------------------
module permutation_step_generator #(
  parameter int unsigned MAX_ELEMS = psg_pkg::MAX_ELEMS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input items
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               restart_i,
  // result items
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [3:0]                         elem_value_o,
  output logic [2:0]                         elem_position_o,
  output logic                               last_elem_o,
  output logic                               finished_o,
  // configuration
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [psg_pkg::ELEM_COUNT_W-1:0]   cfg_elem_count_i
);

  localparam int unsigned IW = $clog2(MAX_ELEMS);
  localparam int unsigned CW = $clog2(MAX_ELEMS + 1);
  localparam int unsigned EW = CW + 1;

  logic [psg_pkg::ELEM_COUNT_W-1:0] elem_count_q;
  logic [CW-1:0]                    n_act;

  logic                             busy;
  logic                             in_fire;
  logic                             slot_free;
  logic                             push;
  psg_pkg::out_item_t               item;
  psg_pkg::st_ctl_t                 st_ctl;
  logic [IW-1:0]                    rd_addr;
  logic [IW-1:0]                    wr_addr;
  logic [EW-1:0]                    wr_data;
  logic [EW-1:0]                    rd_data;
  logic [IW-1:0]                    rd_idx;

  logic                             out_valid_q;
  psg_pkg::out_item_t               out_item_q;

  // Configuration register; always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_count_q <= psg_pkg::ELEM_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      elem_count_q <= cfg_elem_count_i;
    end
  end

  // Active count: zero acts as one, above build size acts as build size
  always_comb begin
    if (elem_count_q == '0) begin
      n_act = CW'(1);
    end else if (int'(elem_count_q) > int'(MAX_ELEMS)) begin
      n_act = CW'(MAX_ELEMS);
    end else begin
      n_act = CW'(elem_count_q);
    end
  end

  assign in_stall_o = busy;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Output register frees when empty or being taken this cycle
  assign slot_free = !out_valid_q || !out_stall_i;

  psg_store #(
    .MAX_ELEMS (MAX_ELEMS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (st_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data),
    .rd_idx_o  (rd_idx)
  );

  psg_ctrl #(
    .MAX_ELEMS (MAX_ELEMS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .restart_i   (restart_i),
    .n_i         (n_act),
    .slot_free_i (slot_free),
    .rd_data_i   (rd_data),
    .rd_idx_i    (rd_idx),
    .busy_o      (busy),
    .st_ctl_o    (st_ctl),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .push_o      (push),
    .item_o      (item)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_item_q <= item;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign elem_value_o    = out_item_q.value;
  assign elem_position_o = out_item_q.position;
  assign last_elem_o     = out_item_q.last;
  assign finished_o      = out_item_q.finished;

endmodule

/* design/psg_checker.sv */
// ----------------------------------------------------------------------------
// psg_checker: port-level checks for the permutation step generator
// Watches the top-level ports; attached by bind.
// ----------------------------------------------------------------------------
module psg_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             restart_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [3:0]                       elem_value_o,
  input logic [2:0]                       elem_position_o,
  input logic                             last_elem_o,
  input logic                             finished_o,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o,
  input logic [psg_pkg::ELEM_COUNT_W-1:0] cfg_elem_count_i
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(elem_value_o) && $stable(elem_position_o)
      && $stable(last_elem_o) && $stable(finished_o))
    else $error("result payload changed while stalled");

  // Finished result is a lone closing item with zero fields
  a_fin_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> last_elem_o && (elem_value_o == 4'd0)
      && (elem_position_o == 3'd0))
    else $error("malformed finished result");

  // Input is stalled right after acceptance
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken back to back");

endmodule

bind permutation_step_generator psg_checker u_psg_checker (.*);
